@@ hdl/fbfla_pkg.sv @@
// Shared types and constants for the fixed-block free-list allocator.
// No dependencies; imported by fbfla_idx_div, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package fbfla_pkg;

    localparam int ADDR_W = 32;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic [ADDR_W-1:0] overflow_count;
        logic              owned;
        logic [ADDR_W-1:0] block_address;
        logic              granted;
    } t_result;

    localparam int RESULT_W = $bits(t_result);
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

@@ hdl/fbfla_idx_div.sv @@
// Reciprocal-multiply unit: registers a pool offset, then the block index for it.
// Depends on fbfla_pkg for the request struct.
`timescale 1ns / 1ps
`default_nettype none

module fbfla_idx_div #(
    parameter int IDX_W   = 6,
    parameter int DIVISOR = 2048
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  fbfla_pkg::t_div_req  i_req,
    output logic                 o_done,
    output logic [IDX_W-1:0]     o_quotient
);
    import fbfla_pkg::*;

    localparam int DVS_W  = $clog2(DIVISOR);
    localparam int OFF_W  = IDX_W + DVS_W;
    localparam int SHIFT  = OFF_W + DVS_W;
    localparam int MUL_W  = OFF_W + 1;
    localparam int PROD_W = OFF_W + MUL_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MUL_W-1:0] RECIP = MUL_W'(RECIP_FULL);

    logic              r_busy;
    logic              r_done;
    logic [OFF_W-1:0]  r_dvd;
    logic [IDX_W-1:0]  r_quo;
    logic [PROD_W-1:0] w_prod;

    assign w_prod     = PROD_W'(r_dvd) * PROD_W'(RECIP);
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_req.start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend[OFF_W-1:0];
        end
        if (r_busy) begin
            r_quo <= w_prod[SHIFT +: IDX_W];
        end
    end

endmodule

`default_nettype wire

@@ hdl/fixed_block_free_list_allocator_top.sv @@
// Fixed-block pool allocator: LIFO free list in a link memory plus a head register.
// Depends on fbfla_pkg and fbfla_idx_div.
//
// Usage:
//   Input stream s_axis carries one request per transaction: tuser holds the
//   operation (allocate, release, query) and the null-handle flag, tdata the
//   requested size and the handle address. Output stream m_axis returns one
//   result per request: grant flag, block address, ownership flag and the
//   running count of failed allocations.
//   The configuration channel writes pool_base; write it only while idle.
//   Requests are taken one at a time, only while the block is idle:
//     query, null or out-of-pool release, failed allocate: result is registered directly;
//     successful allocate: result follows the registered link memory read;
//     in-pool release: result follows the reciprocal multiply, which registers
//     the offset and then the block index that it maps to.
//   After reset an init pass writes every link memory entry so that
//   block i links to block i-1; s_axis_tready stays low during that pass.
//   When the receiver stalls, one finished result waits in the output
//   register, the next request is still taken and its result is held
//   internally; further requests wait until the output drains.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_free_list_allocator_top #(
    parameter int BLOCKS      = 64,
    parameter int BLOCK_BYTES = 2048
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [fbfla_pkg::ADDR_W-1:0]     i_cfg_data,      // pool_base
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [63:0]                      s_axis_tdata,    // request_bytes, handle_address
    input  wire  [2:0]                       s_axis_tuser,    // operation, handle_is_null
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [fbfla_pkg::M_DATA_W-1:0]   m_axis_tdata     // granted, block_address,
                                                              // owned, overflow_count
);
    import fbfla_pkg::*;

    localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam logic [ADDR_W:0] POOL_SIZE = (ADDR_W + 1)'(BLOCKS) * (ADDR_W + 1)'(BLOCK_BYTES);

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_LOOK = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_HOLD = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_init_idx;
    logic [IDX_W-1:0]  r_head, n_head;
    logic              r_head_v, n_head_v;
    logic [ADDR_W-1:0] r_fail, n_fail;
    logic [ADDR_W-1:0] r_base;
    logic              r_m_valid;
    t_result           r_m_res;
    t_result           r_pend;

    logic [IDX_W:0]    r_link_mem [BLOCKS];
    logic [IDX_W:0]    r_link_rd;
    logic              w_mem_re;
    logic              w_mem_we;
    logic [IDX_W-1:0]  w_mem_waddr;
    logic [IDX_W:0]    w_mem_wdata;

    logic              w_accept;
    logic [1:0]        w_op;
    logic              w_null;
    logic [ADDR_W-1:0] w_req_bytes;
    logic [ADDR_W-1:0] w_addr;
    logic [ADDR_W-1:0] w_offset;
    logic              w_in_pool;
    logic [ADDR_W-1:0] w_blk_off;
    logic              w_out_free;
    logic              w_res_valid;
    t_result           w_res;
    t_div_req          w_div_req;
    logic              w_div_done;
    logic [IDX_W-1:0]  w_div_quo;

    fbfla_idx_div #(
        .IDX_W   (IDX_W),
        .DIVISOR (BLOCK_BYTES)
    ) u_idx_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = M_DATA_W'(r_m_res);

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_op        = s_axis_tuser[1:0];
    assign w_null      = s_axis_tuser[2];
    assign w_req_bytes = s_axis_tdata[31:0];
    assign w_addr      = s_axis_tdata[63:32];
    assign w_offset    = w_addr - r_base;
    assign w_in_pool   = ({1'b0, w_offset} < POOL_SIZE);
    assign w_blk_off   = ADDR_W'(r_head) * ADDR_W'(BLOCK_BYTES);
    assign w_out_free  = !r_m_valid || m_axis_tready;

    always_comb begin
        n_state          = r_state;
        n_head           = r_head;
        n_head_v         = r_head_v;
        n_fail           = r_fail;
        w_mem_re         = 1'b0;
        w_mem_we         = 1'b0;
        w_mem_waddr      = r_init_idx;
        w_mem_wdata      = {(r_init_idx != '0), r_init_idx - 1'b1};
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_offset;
        w_res_valid      = 1'b0;
        w_res            = '0;
        unique case (r_state)
            ST_INIT: begin
                w_mem_we = 1'b1;
                if (r_init_idx == IDX_W'(BLOCKS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        OP_ALLOC: begin
                            if ((w_req_bytes > ADDR_W'(BLOCK_BYTES)) || !r_head_v) begin
                                n_fail      = r_fail + 1'b1;
                                w_res_valid = 1'b1;
                            end else begin
                                w_mem_re = 1'b1;
                                n_state  = ST_LOOK;
                            end
                        end
                        OP_RELEASE: begin
                            if (!w_null && w_in_pool) begin
                                w_div_req.start = 1'b1;
                                n_state         = ST_DIV;
                            end else begin
                                w_res_valid = 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            w_res.owned = !w_null && w_in_pool;
                            w_res_valid = 1'b1;
                        end
                        default: begin
                            w_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_LOOK: begin
                n_head              = r_link_rd[IDX_W-1:0];
                n_head_v            = r_link_rd[IDX_W];
                w_res.granted       = 1'b1;
                w_res.block_address = r_base + w_blk_off;
                w_res_valid         = 1'b1;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    w_mem_we    = 1'b1;
                    w_mem_waddr = w_div_quo;
                    w_mem_wdata = {r_head_v, r_head};
                    n_head      = w_div_quo;
                    n_head_v    = 1'b1;
                    w_res_valid = 1'b1;
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        w_res.overflow_count = n_fail;
        if (w_res_valid) begin
            n_state = w_out_free ? ST_IDLE : ST_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_init_idx <= '0;
            r_head     <= IDX_W'(BLOCKS - 1);
            r_head_v   <= 1'b1;
            r_fail     <= '0;
            r_base     <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_head_v <= n_head_v;
            r_fail   <= n_fail;
            if (r_state == ST_INIT) begin
                r_init_idx <= r_init_idx + 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_base <= i_cfg_data;
            end
            if (w_out_free) begin
                r_m_valid <= (r_state == ST_HOLD) || w_res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_m_res <= (r_state == ST_HOLD) ? r_pend : w_res;
        end
        if (w_res_valid && !w_out_free) begin
            r_pend <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_link_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_link_rd <= r_link_mem[r_head];
        end
    end

endmodule

`default_nettype wire

@@ sim/tb_fixed_block_free_list_allocator_top.sv @@
// Self-checking testbench for fixed_block_free_list_allocator_top: drives allocate, release
// and query requests, predicts each result from its own free-list tracker and compares.
// Depends on fbfla_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_fixed_block_free_list_allocator_top;
    import fbfla_pkg::*;

    localparam int          BLOCKS      = 64;
    localparam int          BLOCK_BYTES = 2048;
    localparam logic [31:0] POOL_SPAN   = BLOCKS * BLOCK_BYTES;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int          PHASES      = 5;
    localparam int          PHASE_ITEMS = 380;

    class free_list_tracker;
        logic [31:0] base;
        logic [5:0]  head;
        bit          head_ok;
        logic [5:0]  link [BLOCKS];
        bit          link_ok [BLOCKS];
        bit          held [BLOCKS];
        logic [31:0] fail_cnt;
        t_result     due_results [$];
        int          errors;

        function new();
            base     = '0;
            head     = 6'(BLOCKS - 1);
            head_ok  = 1'b1;
            fail_cnt = '0;
            errors   = 0;
            for (int i = 0; i < BLOCKS; i++) begin
                link[i]    = 6'(i - 1);
                link_ok[i] = (i != 0);
                held[i]    = 1'b0;
            end
        endfunction

        function void note_request(logic [1:0] op, logic [31:0] req, logic [31:0] addr,
                                   bit is_null);
            t_result     r;
            logic [31:0] off;
            logic [5:0]  idx;
            bit          hit;
            r   = '0;
            off = addr - base;
            hit = !is_null && (off < POOL_SPAN);
            idx = 6'(off / BLOCK_BYTES);
            case (op)
                OP_ALLOC: begin
                    if (req > BLOCK_BYTES || !head_ok) begin
                        fail_cnt = fail_cnt + 1;
                    end else begin
                        idx             = head;
                        r.granted       = 1'b1;
                        r.block_address = base + 32'(idx) * BLOCK_BYTES;
                        held[idx]       = 1'b1;
                        head            = link[idx];
                        head_ok         = link_ok[idx];
                    end
                end
                OP_RELEASE: begin
                    if (hit) begin
                        link[idx]    = head;
                        link_ok[idx] = head_ok;
                        head         = idx;
                        head_ok      = 1'b1;
                        held[idx]    = 1'b0;
                    end
                end
                OP_QUERY: r.owned = hit;
                default: ;
            endcase
            r.overflow_count = fail_cnt;
            due_results.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (due_results.size() == 0) begin
                $error("result transaction with no request outstanding");
                errors++;
                return;
            end
            exp = due_results.pop_front();
            if (got.granted !== exp.granted) begin
                $error("granted: expected %0d, got %0d", exp.granted, got.granted);
                errors++;
            end
            if (got.block_address !== exp.block_address) begin
                $error("block_address: expected %h, got %h", exp.block_address,
                       got.block_address);
                errors++;
            end
            if (got.owned !== exp.owned) begin
                $error("owned: expected %0d, got %0d", exp.owned, got.owned);
                errors++;
            end
            if (got.overflow_count !== exp.overflow_count) begin
                $error("overflow_count: expected %0d, got %0d", exp.overflow_count,
                       got.overflow_count);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [ADDR_W-1:0]   i_cfg_data    = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [63:0]         s_axis_tdata  = '0;  // request_bytes, handle_address
    logic [2:0]          s_axis_tuser  = '0;  // operation, handle_is_null
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;        // granted, block_address, owned, overflow_count

    free_list_tracker tracker;
    int send_idle_pct = 0;
    int rx_stall_pct  = 0;
    int hold_len      = 0;
    int hold_left     = 0;

    fixed_block_free_list_allocator_top #(
        .BLOCKS      (BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(negedge i_clk) begin
        if (hold_len != 0) begin
            hold_left = hold_len;
            hold_len  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(t_result'(m_axis_tdata[RESULT_W-1:0]));
    end

    function automatic logic [31:0] block_addr(int idx);
        return tracker.base + 32'(idx) * BLOCK_BYTES;
    endfunction

    function automatic logic [31:0] outside_addr();
        return tracker.base + POOL_SPAN + $urandom_range(32'hFFFF_FFFF - POOL_SPAN);
    endfunction

    task automatic offer_request(input logic [1:0] op, input logic [31:0] req,
                                 input logic [31:0] addr, input bit is_null);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {addr, req};
        s_axis_tuser  <= {is_null, op};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_request(op, req, addr, is_null);
        @(negedge i_clk);
    endtask

    task automatic idle_until_drained();
        s_axis_tvalid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_pool_base(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.base = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_size();
        int sel;
        sel = $urandom_range(99);
        if (sel < 80) return $urandom_range(BLOCK_BYTES);
        if (sel < 90) return BLOCK_BYTES + 1 + $urandom_range(255);
        if (sel < 95) return $urandom;
        case ($urandom_range(3))
            0: return 32'd0;
            1: return BLOCK_BYTES;
            2: return BLOCK_BYTES + 1;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic send_random(input bit grab_heavy, input bit allow_double);
        int          sel;
        int          held_idx [$];
        logic [1:0]  op;
        logic [31:0] req;
        logic [31:0] addr;
        bit          nul;
        req  = $urandom;
        addr = $urandom;
        nul  = ($urandom_range(19) == 0);
        for (int i = 0; i < BLOCKS; i++)
            if (tracker.held[i]) held_idx.push_back(i);
        sel = $urandom_range(99);
        if (sel < 3) begin
            op = OP_UNUSED;
        end else if (sel < (grab_heavy ? 70 : 30)) begin
            op  = OP_ALLOC;
            req = pick_size();
        end else if (sel < 82) begin
            op  = OP_RELEASE;
            sel = $urandom_range(99);
            if (sel < 85 && held_idx.size() != 0)
                addr = block_addr(held_idx[$urandom_range(held_idx.size() - 1)])
                       + $urandom_range(BLOCK_BYTES - 1);
            else if (allow_double && sel < 93)
                addr = tracker.base + $urandom_range(POOL_SPAN - 1);
            else
                addr = outside_addr();
        end else begin
            op  = OP_QUERY;
            sel = $urandom_range(99);
            if (sel < 40) addr = tracker.base + $urandom_range(POOL_SPAN - 1);
            else if (sel < 50) addr = tracker.base - 1;
            else if (sel < 55) addr = tracker.base + POOL_SPAN - 1;
            else if (sel < 60) addr = tracker.base + POOL_SPAN;
            else if (sel < 80) addr = outside_addr();
        end
        offer_request(op, req, addr, nul);
    endtask

    task automatic send_directed();
        logic [31:0] b;
        b = tracker.base;
        offer_request(OP_ALLOC, 32'd0, $urandom, 1'b0);
        offer_request(OP_ALLOC, BLOCK_BYTES, 32'hFFFF_FFFF, 1'b1);
        offer_request(OP_ALLOC, BLOCK_BYTES + 1, $urandom, 1'b0);
        offer_request(OP_ALLOC, 32'hFFFF_FFFF, $urandom, 1'b0);
        offer_request(OP_QUERY, 32'hFFFF_FFFF, b, 1'b0);
        offer_request(OP_QUERY, $urandom, b + POOL_SPAN - 1, 1'b0);
        offer_request(OP_QUERY, $urandom, b + POOL_SPAN, 1'b0);
        offer_request(OP_QUERY, $urandom, b - 1, 1'b0);
        offer_request(OP_QUERY, $urandom, b, 1'b1);
        offer_request(OP_QUERY, 32'd0, 32'hFFFF_FFFF, 1'b1);
        offer_request(OP_QUERY, 32'd0, 32'd0, 1'b0);
        offer_request(OP_RELEASE, $urandom, block_addr(63), 1'b1);
        offer_request(OP_RELEASE, $urandom, b + POOL_SPAN, 1'b0);
        offer_request(OP_RELEASE, $urandom, b - 1, 1'b0);
        offer_request(OP_RELEASE, $urandom, block_addr(63) + BLOCK_BYTES - 1, 1'b0);
        offer_request(OP_UNUSED, $urandom, $urandom, 1'b0);
        offer_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        offer_request(OP_ALLOC, 32'd1, $urandom, 1'b0);
        offer_request(OP_RELEASE, $urandom, block_addr(62), 1'b0);
        offer_request(OP_ALLOC, 32'd0, $urandom, 1'b0);
        offer_request(OP_RELEASE, $urandom, block_addr(62) + 1, 1'b0);
        offer_request(OP_RELEASE, $urandom, block_addr(63) + 32'h400, 1'b0);
    endtask

    initial begin
        logic [31:0] bases [PHASES];
        tracker  = new();
        bases[0] = 32'h0000_0000;
        bases[1] = 32'hFFFF_F800;
        bases[2] = 32'hFFFF_FFFF;
        bases[3] = $urandom & 32'hFFFF_F800;
        bases[4] = $urandom;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                idle_until_drained();
                repeat (12) @(posedge i_clk);
            end else begin
                @(posedge i_clk);
            end
            case (p % 4)
                0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin send_idle_pct = 58; rx_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rx_stall_pct = 58; end
                default: begin send_idle_pct = 24; rx_stall_pct = 24; end
            endcase
            // hold the output side so the block fills and stalls its input
            if (p == 0 || p == 3) hold_len = 300;
            write_pool_base(bases[p]);
            if (p == 0) send_directed();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 250) idle_until_drained();
                send_random(((n / 48) % 2) == 0, (p == PHASES - 1) && (n >= 190));
            end
        end
        idle_until_drained();
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
